[design/rti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, codes and types of the ray / triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int VEC_WIDTH       = 63;
  localparam int DEF_COORD_WIDTH = 21;
  localparam int TOL_WIDTH       = 24;
  localparam int BARY_SHIFT      = 24;
  localparam int CHUNK           = 24;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [TOL_WIDTH-1:0] DET_TOL_RESET  = 24'd128;
  localparam logic [TOL_WIDTH-1:0] BARY_TOL_RESET = 24'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DET_TOL  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BARY_TOL = 8'd1;

  typedef enum logic [2:0] {
    OUT_HIT       = 3'd0,
    OUT_PARALLEL  = 3'd1,
    OUT_U_OUTSIDE = 3'd2,
    OUT_V_OUTSIDE = 3'd3,
    OUT_BEHIND    = 3'd4
  } outcome_t;

  typedef struct packed {
    logic     valid;
    outcome_t outcome;
  } rti_ctl_t;

  typedef struct packed {
    logic [TOL_WIDTH-1:0] det_tol;
    logic [TOL_WIDTH-1:0] bary_tol;
  } rti_tol_t;

endpackage
`default_nettype wire

[design/rti_dot.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rti_dot
// Three-stage exact dot product of an edge vector and a cross product.
// ----------------------------------------------------------------------------
module rti_dot import rti_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic signed [COORD_WIDTH:0]     a [3],
  input  logic signed [2*COORD_WIDTH+2:0] b [3],
  output logic signed [3*COORD_WIDTH+4:0] dot
);

  localparam int EW  = COORD_WIDTH + 1;
  localparam int CW  = 2*COORD_WIDTH + 3;
  localparam int DW  = 3*COORD_WIDTH + 5;
  localparam int LB  = (CW + 1) / 2;
  localparam int HB  = CW - LB;
  localparam int PLW = EW + LB + 1;
  localparam int PHW = EW + HB;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;

  logic signed [PLW-1:0] plo [3];
  logic signed [PHW-1:0] phi [3];
  logic signed [SLW-1:0] slo;
  logic signed [SHW-1:0] shi;

  // split the wide operand into an unsigned low half and a signed high half
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      plo[k] <= a[k] * $signed({1'b0, b[k][LB-1:0]});
      phi[k] <= a[k] * $signed(b[k][CW-1:LB]);
    end
  end

  always_ff @(posedge clk) begin
    slo <= SLW'(plo[0]) + SLW'(plo[1]) + SLW'(plo[2]);
    shi <= SHW'(phi[0]) + SHW'(phi[1]) + SHW'(phi[2]);
  end

  always_ff @(posedge clk) begin
    dot <= (DW'(shi) <<< LB) + DW'(slo);
  end

endmodule
`default_nettype wire

[design/rti_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rti_front
// Edges, cross products, the four dot products and sign normalisation.
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [VEC_WIDTH-1:0]            ray_origin,
  input  logic [VEC_WIDTH-1:0]            ray_direction,
  input  logic [VEC_WIDTH-1:0]            vertex_a,
  input  logic [VEC_WIDTH-1:0]            vertex_b,
  input  logic [VEC_WIDTH-1:0]            vertex_c,
  output logic                            out_valid,
  output logic [3*COORD_WIDTH-1:0]        org_vec,
  output logic [3*COORD_WIDTH-1:0]        dir_vec,
  output logic [3*COORD_WIDTH+3:0]        det_mag,
  output logic signed [3*COORD_WIDTH+4:0] nu,
  output logic signed [3*COORD_WIDTH+4:0] nv,
  output logic signed [3*COORD_WIDTH+5:0] nuv,
  output logic signed [3*COORD_WIDTH+4:0] nt
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int CW  = 2*W + 3;
  localparam int DW  = 3*W + 5;
  localparam int DW1 = DW + 1;
  localparam int MW  = 3*W + 4;
  localparam int NST = 7;

  function automatic logic signed [CW-1:0] xterm(
    input logic signed [EW-1:0] x1,
    input logic signed [EW-1:0] y2,
    input logic signed [EW-1:0] x2,
    input logic signed [EW-1:0] y1
  );
    logic signed [2*EW-1:0] m0;
    logic signed [2*EW-1:0] m1;
    m0 = x1 * y2;
    m1 = x2 * y1;
    return CW'(m0) - CW'(m1);
  endfunction

  logic [NST-1:0]       vld;
  logic [3*W-1:0]       raw_o, raw_d, raw_a, raw_b, raw_c;
  logic [6*W-1:0]       od_dl [NST-1];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] sv [3];
  logic signed [EW-1:0] dx [3];
  logic signed [EW-1:0] e1_3 [3];
  logic signed [EW-1:0] e2_3 [3];
  logic signed [EW-1:0] s_3 [3];
  logic signed [EW-1:0] d_3 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [CW-1:0] q3 [3];
  logic signed [DW-1:0] det6, nu6, nv6, nt6;
  logic signed [DW1-1:0] sum6;
  logic                 neg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: capture the item
  always_ff @(posedge clk) begin
    raw_o <= ray_origin[3*W-1:0];
    raw_d <= ray_direction[3*W-1:0];
    raw_a <= vertex_a[3*W-1:0];
    raw_b <= vertex_b[3*W-1:0];
    raw_c <= vertex_c[3*W-1:0];
  end

  // stage 2: edges and origin offset
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1[k] <= EW'($signed(raw_b[k*W +: W])) - EW'($signed(raw_a[k*W +: W]));
      e2[k] <= EW'($signed(raw_c[k*W +: W])) - EW'($signed(raw_a[k*W +: W]));
      sv[k] <= EW'($signed(raw_o[k*W +: W])) - EW'($signed(raw_a[k*W +: W]));
    end
  end

  // origin and direction ride alongside up to the last stage
  always_ff @(posedge clk) begin
    od_dl[0] <= {raw_d, raw_o};
    for (int i = 1; i < NST-1; i++) begin
      od_dl[i] <= od_dl[i-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = EW'($signed(od_dl[0][3*W + k*W +: W]));
    end
  end

  // stage 3: P = D x E2, Q = S x E1
  always_ff @(posedge clk) begin
    p3[0] <= xterm(dx[1], e2[2], dx[2], e2[1]);
    p3[1] <= xterm(dx[2], e2[0], dx[0], e2[2]);
    p3[2] <= xterm(dx[0], e2[1], dx[1], e2[0]);
    q3[0] <= xterm(sv[1], e1[2], sv[2], e1[1]);
    q3[1] <= xterm(sv[2], e1[0], sv[0], e1[2]);
    q3[2] <= xterm(sv[0], e1[1], sv[1], e1[0]);
    e1_3  <= e1;
    e2_3  <= e2;
    s_3   <= sv;
    d_3   <= dx;
  end

  // stages 4 to 6: determinant and barycentric numerators
  rti_dot #(.COORD_WIDTH(W)) u_det (.clk(clk), .a(e1_3), .b(p3), .dot(det6));
  rti_dot #(.COORD_WIDTH(W)) u_nu  (.clk(clk), .a(s_3),  .b(p3), .dot(nu6));
  rti_dot #(.COORD_WIDTH(W)) u_nv  (.clk(clk), .a(d_3),  .b(q3), .dot(nv6));
  rti_dot #(.COORD_WIDTH(W)) u_nt  (.clk(clk), .a(e2_3), .b(q3), .dot(nt6));

  assign neg6 = det6[DW-1];
  assign sum6 = DW1'(nu6) + DW1'(nv6);

  // stage 7: flip all signs so that the determinant is non-negative
  always_ff @(posedge clk) begin
    det_mag <= MW'(neg6 ? -det6 : det6);
    nu      <= neg6 ? -nu6 : nu6;
    nv      <= neg6 ? -nv6 : nv6;
    nt      <= neg6 ? -nt6 : nt6;
    nuv     <= neg6 ? -sum6 : sum6;
  end

  assign out_valid = vld[NST-1];
  assign org_vec   = od_dl[NST-2][3*W-1:0];
  assign dir_vec   = od_dl[NST-2][6*W-1:3*W];

endmodule
`default_nettype wire

[design/rti_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rti_classify
// Tolerance products, inside / outside tests and hit point numerators.
// ----------------------------------------------------------------------------
module rti_classify import rti_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  rti_tol_t                        tol,
  input  logic [3*COORD_WIDTH-1:0]        org_vec,
  input  logic [3*COORD_WIDTH-1:0]        dir_vec,
  input  logic [3*COORD_WIDTH+3:0]        det_mag,
  input  logic signed [3*COORD_WIDTH+4:0] nu,
  input  logic signed [3*COORD_WIDTH+4:0] nv,
  input  logic signed [3*COORD_WIDTH+5:0] nuv,
  input  logic signed [3*COORD_WIDTH+4:0] nt,
  output rti_ctl_t                        ctl,
  output logic [3*COORD_WIDTH+3:0]        det_out,
  output logic [4*COORD_WIDTH+3:0]        num_mag [3],
  output logic [2:0]                      num_neg
);

  localparam int W    = COORD_WIDTH;
  localparam int MW   = 3*W + 4;
  localparam int DW   = 3*W + 5;
  localparam int NCH  = (MW + CHUNK - 1) / CHUNK;
  localparam int PADW = NCH * CHUNK;
  localparam int TPW  = TOL_WIDTH + CHUNK;
  localparam int OPW  = W + CHUNK + 1;
  localparam int TW   = MW + TOL_WIDTH;
  localparam int NW   = W + MW + 1;
  localparam int AW   = W + MW;
  localparam int SW   = MW + BARY_SHIFT + 2;

  logic [3:0]            vld;
  logic [PADW-1:0]       detp, ntp;

  // stage 1
  logic [TPW-1:0]        tp [NCH];
  logic signed [OPW-1:0] op [3][NCH];
  logic signed [OPW-1:0] dp [3][NCH];
  logic                  par1;
  logic [MW-1:0]         detm1;
  logic signed [DW-1:0]  nu1, nv1, nt1;
  logic signed [DW:0]    nuv1;

  // stage 2
  logic [TW-1:0]         t_sum;
  logic signed [NW-1:0]  od_sum [3];
  logic signed [NW-1:0]  dn_sum [3];
  logic [TW-1:0]         t2;
  logic signed [NW-1:0]  od2 [3];
  logic signed [NW-1:0]  dn2 [3];
  logic                  par2;
  logic [MW-1:0]         detm2;
  logic signed [DW-1:0]  nu2, nv2, nt2;
  logic signed [DW:0]    nuv2;

  // stage 3
  logic signed [SW-1:0]  highb3, tw3;
  logic signed [NW-1:0]  num3 [3];
  logic                  par3;
  logic [MW-1:0]         detm3;
  logic signed [DW-1:0]  nu3, nv3, nt3;
  logic signed [DW:0]    nuv3;

  // stage 4
  logic signed [SW-1:0]  su, sv, suv, sn, lowb;
  outcome_t              oc_next;
  outcome_t              oc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign detp = PADW'(det_mag);
  assign ntp  = PADW'(nt[MW-1:0]);

  // stage 1: chunked partial products; nt is positive whenever a hit survives
  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      tp[i] <= TPW'(tol.bary_tol) * TPW'(detp[i*CHUNK +: CHUNK]);
      for (int k = 0; k < 3; k++) begin
        op[k][i] <= $signed(org_vec[k*W +: W]) * $signed({1'b0, detp[i*CHUNK +: CHUNK]});
        dp[k][i] <= $signed(dir_vec[k*W +: W]) * $signed({1'b0, ntp[i*CHUNK +: CHUNK]});
      end
    end
    par1  <= (det_mag == '0) || (det_mag < MW'(tol.det_tol));
    detm1 <= det_mag;
    nu1   <= nu;
    nv1   <= nv;
    nt1   <= nt;
    nuv1  <= nuv;
  end

  always_comb begin
    t_sum = '0;
    for (int i = 0; i < NCH; i++) begin
      t_sum = t_sum + (TW'(tp[i]) << (i*CHUNK));
    end
    for (int k = 0; k < 3; k++) begin
      od_sum[k] = '0;
      dn_sum[k] = '0;
      for (int i = 0; i < NCH; i++) begin
        od_sum[k] = od_sum[k] + (NW'(op[k][i]) <<< (i*CHUNK));
        dn_sum[k] = dn_sum[k] + (NW'(dp[k][i]) <<< (i*CHUNK));
      end
    end
  end

  // stage 2: gather the partial products
  always_ff @(posedge clk) begin
    t2    <= t_sum;
    od2   <= od_sum;
    dn2   <= dn_sum;
    par2  <= par1;
    detm2 <= detm1;
    nu2   <= nu1;
    nv2   <= nv1;
    nt2   <= nt1;
    nuv2  <= nuv1;
  end

  // stage 3: upper bound det * (1 + tol) and full numerators
  always_ff @(posedge clk) begin
    highb3 <= $signed(SW'(detm2) << BARY_SHIFT) + $signed(SW'(t2));
    tw3    <= $signed(SW'(t2));
    for (int k = 0; k < 3; k++) begin
      num3[k] <= od2[k] + dn2[k];
    end
    par3  <= par2;
    detm3 <= detm2;
    nu3   <= nu2;
    nv3   <= nv2;
    nt3   <= nt2;
    nuv3  <= nuv2;
  end

  assign su   = SW'(nu3) <<< BARY_SHIFT;
  assign sv   = SW'(nv3) <<< BARY_SHIFT;
  assign suv  = SW'(nuv3) <<< BARY_SHIFT;
  assign sn   = SW'(nt3) <<< BARY_SHIFT;
  assign lowb = -tw3;

  // tests in priority order
  always_comb begin
    if (par3) begin
      oc_next = OUT_PARALLEL;
    end else if ((su < lowb) || (highb3 < su)) begin
      oc_next = OUT_U_OUTSIDE;
    end else if ((sv < lowb) || (highb3 < suv)) begin
      oc_next = OUT_V_OUTSIDE;
    end else if (!(tw3 < sn)) begin
      oc_next = OUT_BEHIND;
    end else begin
      oc_next = OUT_HIT;
    end
  end

  // stage 4: outcome, numerator magnitude and sign
  always_ff @(posedge clk) begin
    oc4     <= oc_next;
    det_out <= detm3;
    for (int k = 0; k < 3; k++) begin
      num_mag[k] <= AW'(num3[k][NW-1] ? -num3[k] : num3[k]);
      num_neg[k] <= num3[k][NW-1];
    end
  end

  assign ctl = '{valid: vld[3], outcome: oc4};

endmodule
`default_nettype wire

[design/rti_divide.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rti_divide
// Restoring divider, one quotient bit a stage, then saturation and packing.
// ----------------------------------------------------------------------------
module rti_divide import rti_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rti_ctl_t                 ctl,
  input  logic [3*COORD_WIDTH+3:0] det_mag,
  input  logic [4*COORD_WIDTH+3:0] num_mag [3],
  input  logic [2:0]               num_neg,
  output logic                     result_valid,
  output logic                     hit,
  output outcome_t                 outcome,
  output logic [VEC_WIDTH-1:0]     hit_point
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = 3*W + 4;
  localparam int AW = W + MW;
  localparam logic [W-1:0] MAXC = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINC = {1'b1, {(W-1){1'b0}}};

  logic [W:0]    vld;
  outcome_t      oc  [W+1];
  logic [MW-1:0] dm  [W+1];
  logic [AW-1:0] rem [W+1][3];
  logic [W-1:0]  quo [W+1][3];
  logic [2:0]    ovf [W+1];
  logic [2:0]    ngv [W+1];

  logic [VEC_WIDTH-1:0] pack_next;
  logic [W-1:0]         val;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[W-1:0], ctl.valid};
    end
  end

  // entry stage: flag quotients that cannot fit in the coordinate width
  always_ff @(posedge clk) begin
    oc[0]  <= ctl.outcome;
    dm[0]  <= det_mag;
    ngv[0] <= num_neg;
    for (int k = 0; k < 3; k++) begin
      rem[0][k] <= num_mag[k];
      quo[0][k] <= '0;
      ovf[0][k] <= num_mag[k] >= (AW'(det_mag) << W);
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_step
    localparam int BIT = W - j;
    logic [AW-1:0] dsh;
    assign dsh = AW'(dm[j-1]) << BIT;

    always_ff @(posedge clk) begin
      oc[j]  <= oc[j-1];
      dm[j]  <= dm[j-1];
      ngv[j] <= ngv[j-1];
      ovf[j] <= ovf[j-1];
      for (int k = 0; k < 3; k++) begin
        if (rem[j-1][k] >= dsh) begin
          rem[j][k]      <= rem[j-1][k] - dsh;
          quo[j][k]      <= quo[j-1][k] | (W'(1) << BIT);
        end else begin
          rem[j][k]      <= rem[j-1][k];
          quo[j][k]      <= quo[j-1][k];
        end
      end
    end
  end

  // truncate toward zero, clamp to the coordinate range, drop on a miss
  always_comb begin
    pack_next = '0;
    val       = '0;
    for (int k = 0; k < 3; k++) begin
      if (ngv[W][k]) begin
        val = (ovf[W][k] || (quo[W][k] > MINC)) ? MINC : W'(-quo[W][k]);
      end else begin
        val = (ovf[W][k] || quo[W][k][W-1]) ? MAXC : quo[W][k];
      end
      pack_next[k*W +: W] = val;
    end
    if (oc[W] != OUT_HIT) begin
      pack_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    hit       <= (oc[W] == OUT_HIT);
    outcome   <= oc[W];
    hit_point <= pack_next;
  end

endmodule
`default_nettype wire

[design/ray_triangle_intersect.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipelined ray / triangle hit test with exact fixed-point arithmetic.
// ----------------------------------------------------------------------------
// Pulse start with a ray and a triangle in any cycle: busy never rises, so
// one item enters every clock, and its result appears on hit, outcome and
// hit_point for one cycle, marked by result_valid. Results come out in
// order and cannot be held off, so capture them when the strobe is high.
// The divider that forms the hit point ends the pipeline: one quotient bit
// per stage, with seven front stages for edges, cross and dot products and
// four for the tolerance tests ahead of it. Write the two tolerances only
// while no item is in flight; the port takes a write in every cycle, and
// indexes beyond the two registers are dropped. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [VEC_WIDTH-1:0]       ray_origin,
  input  logic [VEC_WIDTH-1:0]       ray_direction,
  input  logic [VEC_WIDTH-1:0]       vertex_a,
  input  logic [VEC_WIDTH-1:0]       vertex_b,
  input  logic [VEC_WIDTH-1:0]       vertex_c,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [TOL_WIDTH-1:0]       cfg_data,
  output logic                       result_valid,
  output logic                       hit,
  output logic [2:0]                 outcome,
  output logic [VEC_WIDTH-1:0]       hit_point
);

  localparam int W = COORD_WIDTH;

  rti_tol_t tol;

  logic                     fr_valid;
  logic [3*W-1:0]           fr_org, fr_dir;
  logic [3*W+3:0]           fr_det;
  logic signed [3*W+4:0]    fr_nu, fr_nv, fr_nt;
  logic signed [3*W+5:0]    fr_nuv;

  rti_ctl_t                 cl_ctl;
  logic [3*W+3:0]           cl_det;
  logic [4*W+3:0]           cl_mag [3];
  logic [2:0]               cl_neg;

  outcome_t                 dv_outcome;

  // the pipeline never stalls, so accept every item and every write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // tolerance registers; writes to unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      tol.det_tol  <= DET_TOL_RESET;
      tol.bary_tol <= BARY_TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DET_TOL:  tol.det_tol  <= cfg_data;
        REG_BARY_TOL: tol.bary_tol <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // edges, cross products, determinant and numerators, signs normalised
  rti_front #(.COORD_WIDTH(W)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .ray_origin    (ray_origin),
    .ray_direction (ray_direction),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .out_valid     (fr_valid),
    .org_vec       (fr_org),
    .dir_vec       (fr_dir),
    .det_mag       (fr_det),
    .nu            (fr_nu),
    .nv            (fr_nv),
    .nuv           (fr_nuv),
    .nt            (fr_nt)
  );

  // parallel, barycentric and distance tests plus hit point numerators
  rti_classify #(.COORD_WIDTH(W)) u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .tol      (tol),
    .org_vec  (fr_org),
    .dir_vec  (fr_dir),
    .det_mag  (fr_det),
    .nu       (fr_nu),
    .nv       (fr_nv),
    .nuv      (fr_nuv),
    .nt       (fr_nt),
    .ctl      (cl_ctl),
    .det_out  (cl_det),
    .num_mag  (cl_mag),
    .num_neg  (cl_neg)
  );

  // hit point = numerator / determinant per component, clamped
  rti_divide #(.COORD_WIDTH(W)) u_divide (
    .clk          (clk),
    .rst          (rst),
    .ctl          (cl_ctl),
    .det_mag      (cl_det),
    .num_mag      (cl_mag),
    .num_neg      (cl_neg),
    .result_valid (result_valid),
    .hit          (hit),
    .outcome      (dv_outcome),
    .hit_point    (hit_point)
  );

  assign outcome = dv_outcome;

endmodule
`default_nettype wire

[tb/ray_triangle_intersect_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test
// Self-checking bench for the ray / triangle hit test. A short table of
// hand-built rays and triangles comes first. Random items follow, most of them
// aimed at a random point on or near a random triangle. Items not typed in
// by hand have outcome and hit point predicted with exact 128-bit arithmetic.
// Tolerances are changed between phases, and only while the pipeline is empty.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;
  import rti_pkg::*;

  localparam int CW         = DEF_COORD_WIDTH;
  localparam int LATENCY    = CW + 13;
  localparam int SETTLE     = LATENCY + 8;
  localparam int RAND_ITEMS = 1950;
  localparam int CYCLE_CAP  = 400000;
  localparam int MAXC       = (1 << (CW - 1)) - 1;
  localparam int MINC       = -(1 << (CW - 1));
  localparam int ONE        = 1024;            // 1.0 in Q11.10
  localparam logic [TOL_WIDTH-1:0] TOL_MAX = '1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 8'd5;

  typedef logic signed [127:0] wide_t;
  typedef logic [VEC_WIDTH-1:0] vec_t;

  typedef struct {
    logic     hit;
    outcome_t oc;
    vec_t     pt;
  } hit_result_t;

  typedef struct {
    vec_t        o, d, a, b, c;
    bit          known;   // expectation typed in below, not predicted
    hit_result_t res;
  } probe_t;

  logic clk, rst, start, busy;
  vec_t ray_origin, ray_direction, vertex_a, vertex_b, vertex_c;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [TOL_WIDTH-1:0] cfg_data;
  logic result_valid, hit;
  logic [2:0] outcome;
  vec_t hit_point;

  ray_triangle_intersect i_dut (
    .clk, .rst, .start, .busy,
    .ray_origin, .ray_direction, .vertex_a, .vertex_b, .vertex_c,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .result_valid, .hit, .outcome, .hit_point
  );

  // Bench copy of the tolerance registers
  logic [TOL_WIDTH-1:0] det_tol_copy, bary_tol_copy;

  hit_result_t pending_results[$];
  probe_t      probes[$];
  int unsigned fails, cycles, items_sent;
  int unsigned outcome_seen[5];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cap the run in case the pipeline hangs or drops results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("ray_triangle_intersect_test NOT OK");
      $finish;
    end
  end

  function automatic vec_t pack3(input longint x, input longint y, input longint z);
    logic [CW-1:0] px, py, pz;
    px = x[CW-1:0];
    py = y[CW-1:0];
    pz = z[CW-1:0];
    return {pz, py, px};
  endfunction

  function automatic wide_t coord(input vec_t v, input int k);
    logic [CW-1:0] raw;
    raw = v[k*CW +: CW];
    return {{(128 - CW){raw[CW-1]}}, raw};
  endfunction

  // Exact Moller-Trumbore: integer numerators, no division but for the point
  function automatic hit_result_t predict_intersection(input vec_t vo, vd, va, vb, vc);
    wide_t o[3], d[3], e1[3], e2[3], s[3], p[3], q[3];
    wide_t det, nu, nv, nt, tolw, lowb, highb, su, sv, num, qv;
    hit_result_t r;
    for (int k = 0; k < 3; k++) begin
      o[k]  = coord(vo, k);
      d[k]  = coord(vd, k);
      e1[k] = coord(vb, k) - coord(va, k);
      e2[k] = coord(vc, k) - coord(va, k);
      s[k]  = o[k] - coord(va, k);
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // fold the sign of det into the numerators
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    tolw  = wide_t'(bary_tol_copy);
    lowb  = -(tolw * det);
    highb = ((wide_t'(1) <<< BARY_SHIFT) + tolw) * det;
    su    = nu <<< BARY_SHIFT;
    sv    = nv <<< BARY_SHIFT;
    r.pt  = '0;
    if (det == 0 || det < wide_t'(det_tol_copy))
      r.oc = OUT_PARALLEL;
    else if (su < lowb || su > highb)
      r.oc = OUT_U_OUTSIDE;
    else if (sv < lowb || su + sv > highb)
      r.oc = OUT_V_OUTSIDE;
    else if (tolw * det >= (nt <<< BARY_SHIFT))
      r.oc = OUT_BEHIND;
    else
      r.oc = OUT_HIT;
    r.hit = (r.oc == OUT_HIT);
    if (r.hit) begin
      for (int k = 0; k < 3; k++) begin
        num = o[k] * det + nt * d[k];
        qv  = num / det;               // truncates toward zero
        if (qv > MAXC) qv = MAXC;
        if (qv < MINC) qv = MINC;
        r.pt[k*CW +: CW] = qv[CW-1:0];
      end
    end
    return r;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: hit %0b outcome %0d point %h",
                 $time, hit, outcome, hit_point);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          fails++;
        end
        if (outcome !== want.oc) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.oc, outcome);
          fails++;
        end
        if (hit_point !== want.pt) begin
          $display("%0t: hit_point expected %h actual %h", $time, want.pt, hit_point);
          fails++;
        end
        if (want.oc <= OUT_BEHIND) outcome_seen[want.oc]++;
      end
    end
  end

  // Offer one item from the falling edge and hold it until it is taken
  task automatic drive_item(input probe_t pr);
    bit taken;
    @(negedge clk);
    start         <= 1'b1;
    ray_origin    <= pr.o;
    ray_direction <= pr.d;
    vertex_a      <= pr.a;
    vertex_b      <= pr.b;
    vertex_c      <= pr.c;
    do begin
      taken = !busy;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    pending_results.push_back(pr.known ? pr.res :
                              predict_intersection(pr.o, pr.d, pr.a, pr.b, pr.c));
    items_sent++;
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drain the pipeline, then let the tail settle
  task automatic wait_idle();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [TOL_WIDTH-1:0] val);
    bit taken;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      taken = cfg_ready;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    if (idx == REG_DET_TOL) det_tol_copy = val;
    else if (idx == REG_BARY_TOL) bary_tol_copy = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint spread(input longint r);
    return longint'($urandom_range(32'(2 * r))) - r;
  endfunction

  // Mostly rays aimed at a point on or near a random triangle; the rest
  // are raw bit patterns, tiny triangles and rays parallel to the plane.
  function automatic probe_t random_probe();
    probe_t pr;
    longint r, ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz, px, py, pz, pu, pv, m;
    int unsigned pick;
    pick = $urandom_range(99);
    pr.known = 1'b0;
    pr.res   = '{1'b0, OUT_HIT, '0};
    r  = longint'(1) << $urandom_range(19, 3);
    ax = spread(r); ay = spread(r); az = spread(r);
    bx = spread(r); by = spread(r); bz = spread(r);
    cx = spread(r); cy = spread(r); cz = spread(r);
    ox = spread(r); oy = spread(r); oz = spread(r);
    pr.a = pack3(ax, ay, az);
    pr.b = pack3(bx, by, bz);
    pr.c = pack3(cx, cy, cz);
    pr.o = pack3(ox, oy, oz);
    if (pick < 65) begin
      // barycentrics in thousandths, a few just outside the triangle
      pu = longint'($urandom_range(1100)) - 50;
      pv = longint'($urandom_range(1100)) - 50;
      if ($urandom_range(3) != 0 && pu + pv > 1000) begin
        pu = 1000 - pu;
        pv = 1000 - pv;
      end
      px = ax + ((bx - ax) * pu + (cx - ax) * pv) / 1000;
      py = ay + ((by - ay) * pu + (cy - ay) * pv) / 1000;
      pz = az + ((bz - az) * pu + (cz - az) * pv) / 1000;
      m  = longint'($urandom_range(8, 1));
      pr.d = pack3((px - ox) * m / 4, (py - oy) * m / 4, (pz - oz) * m / 4);
      if ($urandom_range(7) == 0)
        pr.d = pack3(-(px - ox), -(py - oy), -(pz - oz));
    end else if (pick < 85) begin
      pr.o = VEC_WIDTH'({$urandom, $urandom});
      pr.d = VEC_WIDTH'({$urandom, $urandom});
      pr.a = VEC_WIDTH'({$urandom, $urandom});
      pr.b = VEC_WIDTH'({$urandom, $urandom});
      pr.c = VEC_WIDTH'({$urandom, $urandom});
    end else if (pick < 93) begin
      pr.a = pack3(spread(4), spread(4), spread(4));
      pr.b = pack3(spread(4), spread(4), spread(4));
      pr.c = pack3(spread(4), spread(4), spread(4));
      pr.d = pack3(spread(4), spread(4), spread(4));
    end else begin
      pr.d = pack3(bx - ax, by - ay, bz - az);   // in the plane: det is zero
    end
    return pr;
  endfunction

  task automatic run_probes();
    foreach (probes[i]) begin
      drive_item(probes[i]);
      if ($urandom_range(3) == 0) pause_sender($urandom_range(3, 1));
    end
  endtask

  task automatic random_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(40, 1);
      for (int i = 0; i < burst && n > 0; i++, n--) drive_item(random_probe());
      if ($urandom_range(4) != 0) pause_sender($urandom_range(6, 1));
    end
  endtask

  task automatic set_tolerances(input logic [TOL_WIDTH-1:0] dt, bt);
    wait_idle();
    write_reg(REG_DET_TOL, dt);
    write_reg(REG_BARY_TOL, bt);
  endtask

  function automatic probe_t mk(input vec_t o, d, a, b, c, input bit known = 1'b0,
                                input outcome_t oc = OUT_HIT, input vec_t pt = '0);
    probe_t pr;
    pr = '{o, d, a, b, c, known, '{oc == OUT_HIT, oc, pt}};
    return pr;
  endfunction

  initial begin
    vec_t zero, ta, tb, tc, down;
    zero = '0;
    ta   = pack3(0, 0, 0);
    tb   = pack3(ONE, 0, 0);
    tc   = pack3(0, ONE, 0);
    down = pack3(0, 0, -ONE);

    rst = 1'b1;
    start = 1'b0;
    ray_origin = '0; ray_direction = '0;
    vertex_a = '0; vertex_b = '0; vertex_c = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    det_tol_copy  = DET_TOL_RESET;
    bary_tol_copy = BARY_TOL_RESET;

    // Unit triangle in z = 0, rays shot mostly down the z axis
    probes.push_back(mk(zero, zero, zero, zero, zero, 1'b1, OUT_PARALLEL));
    probes.push_back(mk(pack3(256, 256, ONE), down, ta, tb, tc, 1'b1, OUT_HIT,
                        pack3(256, 256, 0)));
    // swapped winding gives a negative determinant, same point
    probes.push_back(mk(pack3(256, 256, ONE), down, ta, tc, tb, 1'b1, OUT_HIT,
                        pack3(256, 256, 0)));
    probes.push_back(mk(pack3(256, 256, ONE), pack3(0, 0, ONE), ta, tb, tc, 1'b1,
                        OUT_BEHIND));
    probes.push_back(mk(pack3(2 * ONE, 256, ONE), down, ta, tb, tc, 1'b1, OUT_U_OUTSIDE));
    probes.push_back(mk(pack3(256, 2 * ONE, ONE), down, ta, tb, tc, 1'b1, OUT_V_OUTSIDE));
    probes.push_back(mk(pack3(256, 256, ONE), pack3(ONE, 0, 0), ta, tb, tc, 1'b1,
                        OUT_PARALLEL));
    // on the u = 0 edge, on the u + v = 1 edge, origin on the triangle
    probes.push_back(mk(pack3(0, 256, ONE), down, ta, tb, tc));
    probes.push_back(mk(pack3(512, 512, ONE), down, ta, tb, tc));
    probes.push_back(mk(pack3(256, 256, 0), down, ta, tb, tc));
    // tiny determinant below the parallel bound
    probes.push_back(mk(pack3(0, 0, 1), pack3(0, 0, -1), ta, pack3(1, 0, 0), pack3(0, 1, 0)));
    // field extremes
    probes.push_back(mk('1, '1, '1, '1, '1));
    probes.push_back(mk(pack3(MAXC, MAXC, MAXC), pack3(MINC, MINC, MINC),
                        pack3(MAXC, MINC, MAXC), pack3(MINC, MAXC, MINC), zero));
    probes.push_back(mk({21{3'b101}}, {21{3'b010}}, {21{3'b110}}, {21{3'b011}},
                        {21{3'b001}}));
    // full-range triangle hit from the far corner
    probes.push_back(mk(pack3(0, 0, MAXC), pack3(0, 0, MINC), pack3(MINC, MINC, 0),
                        pack3(MAXC, MINC, 0), pack3(MINC, MAXC, 0)));
    // far hit point past the range: saturates once the slack allows u near 1.5
    probes.push_back(mk(pack3(0, 0, ONE), pack3(MAXC, 0, -683), ta,
                        pack3(MAXC, 0, 0), pack3(0, MAXC, 0)));
    probes.push_back(mk(pack3(0, 0, ONE), pack3(MINC, MINC, -683), ta,
                        pack3(MINC, 0, 0), pack3(0, MINC, 0)));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass on reset tolerances, then again with the widest slack
    run_probes();
    set_tolerances('0, TOL_MAX);
    foreach (probes[i]) probes[i].known = 1'b0;
    run_probes();

    // Random phases across the tolerance range; an unknown index is dropped
    set_tolerances(TOL_MAX, '0);
    write_reg(REG_UNUSED, 24'h000001);
    random_phase(RAND_ITEMS / 6);
    set_tolerances('0, '0);
    random_phase(RAND_ITEMS / 6);
    set_tolerances(TOL_MAX, TOL_MAX);
    random_phase(RAND_ITEMS / 6);
    set_tolerances(TOL_WIDTH'($urandom_range(4096)), TOL_WIDTH'($urandom_range(1 << 16)));
    random_phase(RAND_ITEMS / 6);
    set_tolerances(TOL_WIDTH'($urandom), TOL_WIDTH'($urandom));
    random_phase(RAND_ITEMS / 6);
    set_tolerances(DET_TOL_RESET, BARY_TOL_RESET);
    random_phase(RAND_ITEMS - 5 * (RAND_ITEMS / 6));

    wait_idle();
    $display("Sent %0d items over seven tolerance settings.", items_sent);
    $display("Outcomes: %0d hit, %0d parallel, %0d u out, %0d v out, %0d behind.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (fails == 0) begin
      $display("ray_triangle_intersect_test OK");
    end else begin
      $display("ray_triangle_intersect_test NOT OK");
    end
    $finish;
  end

endmodule
